### rtl/mrtf_pkg.sv
// Shared types and constants of the multihop route table forwarder.
// Holds the action codes, register indexes, table entry layout and the
// command/status structs between controller and datapath. No dependencies.
package mrtf_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_NODE_ID       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOP_LIMIT         = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROUTE_LIFETIME_MS = 2'd2;

   localparam logic [7:0]  RST_OWN_NODE_ID       = 8'd2;
   localparam logic [7:0]  RST_HOP_LIMIT         = 8'd3;
   localparam logic [31:0] RST_ROUTE_LIFETIME_MS = 32'd300000;

   typedef enum logic [2:0] {
      ACT_DELIVERED      = 3'd0,
      ACT_FORWARDED      = 3'd1,
      ACT_FWD_NO_ROUTE   = 3'd2,
      ACT_FWD_HOP_LIMIT  = 3'd3,
      ACT_DROPPED        = 3'd4,
      ACT_SENT           = 3'd5,
      ACT_SEND_NO_ROUTE  = 3'd6,
      ACT_SEND_HOP_LIMIT = 3'd7
   } action_type;

   typedef struct packed {
      logic [7:0]        node;
      logic [7:0]        hops;
      logic signed [7:0] rssi;
      logic [31:0]       stamp;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load_item;
      logic scan_go;
      logic route_mode;
      logic learn_commit;
      logic load_result;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic item_func;
      logic scan_busy;
   } sts_type;

endpackage

### rtl/mrtf_ctrl.sv
// Sequencing controller of the route table forwarder.
// Steps each received header through learn scan, table update, route scan
// and result handoff; a local send skips to the route scan. Depends on mrtf_pkg.
module mrtf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  mrtf_pkg::sts_type sts,
   output mrtf_pkg::cmd_type cmd
);
   import mrtf_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_DISPATCH = 7'b0000010,
      ST_LSCAN    = 7'b0000100,
      ST_LCOMMIT  = 7'b0001000,
      ST_RSTART   = 7'b0010000,
      ST_RSCAN    = 7'b0100000,
      ST_FINISH   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.load_item    = (state_ff == ST_IDLE) && req_valid;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            // local send skips the table refresh
            cmd.scan_go    = 1'b1;
            cmd.route_mode = sts.item_func;
            state_in       = sts.item_func ? ST_RSCAN : ST_LSCAN;
         end
         ST_LSCAN: begin
            if (!sts.scan_busy) state_in = ST_LCOMMIT;
         end
         ST_LCOMMIT: begin
            cmd.learn_commit = 1'b1;
            state_in         = ST_RSTART;
         end
         ST_RSTART: begin
            cmd.scan_go    = 1'b1;
            cmd.route_mode = 1'b1;
            state_in       = ST_RSCAN;
         end
         ST_RSCAN: begin
            if (!sts.scan_busy) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output slot is free
            if (slot_free) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.load_result) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/mrtf_dpath.sv
// Datapath of the route table forwarder: registers, item capture, route
// table memory with a pipelined scan engine, and result registers.
// Depends on mrtf_pkg.
module mrtf_dpath #(
   parameter int TABLE_DEPTH = mrtf_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [mrtf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mrtf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_func,
   input  logic [7:0]                       req_source_id,
   input  logic [7:0]                       req_dest_id,
   input  logic [7:0]                       req_hop_count,
   input  logic signed [7:0]                req_rssi,
   input  logic [31:0]                      req_now_ms,
   input  mrtf_pkg::cmd_type                cmd,
   output mrtf_pkg::sts_type                sts,
   output logic [2:0]                       rsp_action,
   output logic [7:0]                       rsp_out_hop_count,
   output logic                             rsp_route_changed,
   output logic                             rsp_table_full_drop
);
   import mrtf_pkg::*;

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // configuration
   logic [7:0]  own_id_ff;
   logic [7:0]  hop_limit_ff;
   logic [31:0] lifetime_ff;

   // captured item
   logic              func_ff;
   logic [7:0]        src_ff;
   logic [7:0]        dest_ff;
   logic [7:0]        hops_ff;
   logic signed [7:0] rssi_ff;
   logic [31:0]       now_ff;

   // table
   entry_type         mem [TABLE_DEPTH];
   logic [CW-1:0]     count_ff;

   // scan engine
   logic              mode_ff;
   logic              active_ff;
   logic [IW-1:0]     idx_ff;
   logic              cmp_v_ff;
   logic [IW-1:0]     cmp_idx_ff;
   entry_type         rd_ff;
   logic              hit_ff;
   logic [IW-1:0]     hit_idx_ff;
   logic [7:0]        hit_hops_ff;
   logic signed [7:0] hit_rssi_ff;

   logic              changed_ff;
   logic              full_ff;

   // result registers
   action_type        action_ff;
   logic [7:0]        ohops_ff;
   logic              rchanged_ff;
   logic              rfull_ff;

   logic [7:0]        key;
   logic [31:0]       age;
   logic              cmp_match;
   logic              last_issue;
   logic              better;
   logic              room;
   entry_type         new_entry;
   logic [7:0]        fwd_hops;
   action_type        action_in;
   logic [7:0]        ohops_in;

   assign key        = mode_ff ? dest_ff : src_ff;
   assign age        = now_ff - rd_ff.stamp;
   assign cmp_match  = cmp_v_ff && (rd_ff.node == key) && (!mode_ff || (age < lifetime_ff));
   assign last_issue = (CW'(idx_ff) == (count_ff - CW'(1)));
   assign better     = (hops_ff < hit_hops_ff) ||
                       ((hops_ff == hit_hops_ff) && (rssi_ff > hit_rssi_ff));
   assign room       = (count_ff < CW'(TABLE_DEPTH));
   assign new_entry  = '{node: src_ff, hops: hops_ff, rssi: rssi_ff, stamp: now_ff};
   assign fwd_hops   = hops_ff + 8'd1;

   assign sts.item_func = func_ff;
   assign sts.scan_busy = active_ff || cmp_v_ff;

   // final decision; hit_ff holds the route scan outcome here
   always_comb begin
      ohops_in = 8'd0;
      if (func_ff) begin
         ohops_in = hops_ff;
         if (hops_ff >= hop_limit_ff)  action_in = ACT_SEND_HOP_LIMIT;
         else if (!hit_ff)             action_in = ACT_SEND_NO_ROUTE;
         else                          action_in = ACT_SENT;
      end else if (dest_ff == own_id_ff) begin
         action_in = ACT_DELIVERED;
      end else if (hops_ff < hop_limit_ff) begin
         ohops_in = fwd_hops;
         if (fwd_hops >= hop_limit_ff) action_in = ACT_FWD_HOP_LIMIT;
         else if (!hit_ff)             action_in = ACT_FWD_NO_ROUTE;
         else                          action_in = ACT_FORWARDED;
      end else begin
         action_in = ACT_DROPPED;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff    <= RST_OWN_NODE_ID;
         hop_limit_ff <= RST_HOP_LIMIT;
         lifetime_ff  <= RST_ROUTE_LIFETIME_MS;
         count_ff     <= '0;
         active_ff    <= 1'b0;
         cmp_v_ff     <= 1'b0;
         hit_ff       <= 1'b0;
         changed_ff   <= 1'b0;
         full_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_OWN_NODE_ID:       own_id_ff    <= csr_wdata[7:0];
               CSR_HOP_LIMIT:         hop_limit_ff <= csr_wdata[7:0];
               CSR_ROUTE_LIFETIME_MS: lifetime_ff  <= csr_wdata[31:0];
               default: ;
            endcase
         end
         if (cmd.scan_go) begin
            active_ff <= (count_ff != '0);
            cmp_v_ff  <= 1'b0;
            hit_ff    <= 1'b0;
         end else begin
            // stop issuing on the first match or after the last entry
            cmp_v_ff <= active_ff && !cmp_match;
            if (active_ff && (last_issue || cmp_match)) active_ff <= 1'b0;
            if (cmp_match) hit_ff <= 1'b1;
         end
         if (cmd.load_item) begin
            changed_ff <= 1'b0;
            full_ff    <= 1'b0;
         end
         if (cmd.learn_commit) begin
            if (hit_ff) begin
               changed_ff <= better;
            end else if (room) begin
               count_ff   <= count_ff + CW'(1);
               changed_ff <= 1'b1;
            end else begin
               full_ff <= 1'b1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff <= req_func;
         src_ff  <= req_source_id;
         dest_ff <= req_dest_id;
         hops_ff <= req_hop_count;
         rssi_ff <= req_rssi;
         now_ff  <= req_now_ms;
      end
      if (cmd.scan_go) begin
         idx_ff  <= '0;
         mode_ff <= cmd.route_mode;
      end else if (active_ff) begin
         idx_ff <= idx_ff + IW'(1);
      end
      cmp_idx_ff <= idx_ff;
      if (cmp_match) begin
         hit_idx_ff  <= cmp_idx_ff;
         hit_hops_ff <= rd_ff.hops;
         hit_rssi_ff <= rd_ff.rssi;
      end
      if (cmd.load_result) begin
         action_ff   <= action_in;
         ohops_ff    <= ohops_in;
         rchanged_ff <= changed_ff;
         rfull_ff    <= full_ff;
      end
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.learn_commit) begin
         if (hit_ff) begin
            if (better) mem[hit_idx_ff] <= new_entry;
         end else if (room) begin
            mem[count_ff[IW-1:0]] <= new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[idx_ff];
   end

   assign rsp_action          = action_ff;
   assign rsp_out_hop_count   = ohops_ff;
   assign rsp_route_changed   = rchanged_ff;
   assign rsp_table_full_drop = rfull_ff;

endmodule

### rtl/multihop_route_table_forwarder_core.sv
// Top level of the multihop route table forwarder.
// Joins the sequencing controller (mrtf_ctrl) and the datapath (mrtf_dpath).
// Depends on mrtf_pkg.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+----------------------
//   request  | req_func/source_id/dest_id/hop_count/   | req_valid, req_stall
//            | rssi/now_ms                             |
//   response | rsp_action/out_hop_count/route_changed/ | rsp_valid, rsp_stall
//            | table_full_drop                         |
//   csr      | csr_index, csr_wdata                    | csr_we
//
// One transaction at a time. Each table scan reads the stored entries (at most
// TABLE_DEPTH) one entry per cycle from the single memory read port. A finished
// result sits in the output register, and the next transaction is taken while
// it waits. Reset is synchronous and clears the entry count, the scan flags and
// the configuration registers to their defaults; table contents are not
// cleared. req_stall is high from acceptance until the result is loaded.
module multihop_route_table_forwarder_core #(
   parameter int TABLE_DEPTH = mrtf_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [mrtf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mrtf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_func,
   input  logic [7:0]                       req_source_id,
   input  logic [7:0]                       req_dest_id,
   input  logic [7:0]                       req_hop_count,
   input  logic signed [7:0]                req_rssi,
   input  logic [31:0]                      req_now_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_action,
   output logic [7:0]                       rsp_out_hop_count,
   output logic                             rsp_route_changed,
   output logic                             rsp_table_full_drop
);
   import mrtf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mrtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mrtf_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_func            (req_func),
      .req_source_id       (req_source_id),
      .req_dest_id         (req_dest_id),
      .req_hop_count       (req_hop_count),
      .req_rssi            (req_rssi),
      .req_now_ms          (req_now_ms),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_action          (rsp_action),
      .rsp_out_hop_count   (rsp_out_hop_count),
      .rsp_route_changed   (rsp_route_changed),
      .rsp_table_full_drop (rsp_table_full_drop)
   );

   // a new result never overwrites one that is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> !(rsp_valid && rsp_stall))
      else $error("result loaded over a stalled response");

   // no transaction enters while a scan is running
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !sts.scan_busy)
      else $error("request accepted during a table scan");

   // an accepted transaction blocks the request side next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side not stalled after acceptance");

endmodule
